// ===== design/kfd_pkg.sv =====
// kfd_pkg: shared types and constants of the KISS frame deframer
// no dependencies; imported by every module of the block
package kfd_pkg;

  // KISS special characters
  localparam logic [7:0] KISS_FEND  = 8'hC0;
  localparam logic [7:0] KISS_FESC  = 8'hDB;
  localparam logic [7:0] KISS_TFEND = 8'hDC;
  localparam logic [7:0] KISS_TFESC = 8'hDD;

  // reset value of the contact day limit register
  localparam logic [15:0] CONTACT_LIMIT_RST = 16'd7;

  // saturation point of the day counter
  localparam logic [15:0] DAYS_MAX = 16'hFFFF;

  // request kinds on the input stream
  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_DAY  = 1'b1
  } req_e;

  // event codes reported per transfer
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DATA       = 3'd1,
    EV_DONE       = 3'd2,
    EV_ABORT      = 3'd3,
    EV_OUTSIDE    = 3'd4,
    EV_BAD_ESC    = 3'd5,
    EV_OVERFLOW   = 3'd6,
    EV_EXTRA_FEND = 3'd7
  } event_e;

  // configuration register indexes
  typedef enum logic {
    REG_CONTACT_LIMIT = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_e;

  // decoded result of one byte
  typedef struct packed {
    event_e      ev;
    logic [7:0]  data;
    logic [7:0]  pos;
    logic [8:0]  len;
  } dec_res_t;

  // day counter control from the decoder
  typedef struct packed {
    logic tick;
    logic clear;
  } contact_ctl_t;

endpackage

// ===== design/kfd_decoder.sv =====
// kfd_decoder: KISS framing state and per-byte decode logic
// depends on kfd_pkg
module kfd_decoder #(
  parameter int unsigned MAX_FRAME_LEN = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  req_type_i,
  input  logic [7:0]            rx_byte_i,
  output kfd_pkg::dec_res_t     res_o,
  output kfd_pkg::contact_ctl_t ctl_o
);
  import kfd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [CW-1:0] MaxLen = CW'(MAX_FRAME_LEN);

  logic          inside_q, inside_d;
  logic          esc_q, esc_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic       do_store;
  logic [7:0] store_val;

  // next state and result for the item in the input register
  always_comb begin
    inside_d   = inside_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    do_store   = 1'b0;
    store_val  = rx_byte_i;
    res_o      = '0;
    res_o.ev   = EV_NONE;
    ctl_o      = '0;
    priority if (req_type_i == REQ_DAY) begin
      ctl_o.tick = 1'b1;
    end else if (rx_byte_i == KISS_FEND) begin
      priority if (!inside_q) begin
        inside_d = 1'b1;
        esc_d    = 1'b0;
        cnt_d    = '0;
      end else if (cnt_q != '0) begin
        inside_d    = 1'b0;
        esc_d       = 1'b0;
        ctl_o.clear = 1'b1;
        res_o.ev    = EV_DONE;
        res_o.len   = 9'(cnt_q);
      end else begin
        res_o.ev = EV_EXTRA_FEND;
      end
    end else if (!inside_q) begin
      res_o.ev = EV_OUTSIDE;
    end else if (rx_byte_i == KISS_FESC) begin
      if (esc_q) begin
        inside_d = 1'b0;
        esc_d    = 1'b0;
        res_o.ev = EV_ABORT;
      end else begin
        esc_d = 1'b1;
      end
    end else if (rx_byte_i == KISS_TFEND || rx_byte_i == KISS_TFESC) begin
      do_store = 1'b1;
      if (esc_q) begin
        esc_d     = 1'b0;
        store_val = (rx_byte_i == KISS_TFEND) ? KISS_FEND : KISS_FESC;
      end
    end else if (esc_q) begin
      esc_d    = 1'b0;
      res_o.ev = EV_BAD_ESC;
    end else begin
      do_store = 1'b1;
    end

    // store a data byte while the frame has room
    if (do_store) begin
      if (cnt_q < MaxLen) begin
        res_o.ev   = EV_DATA;
        res_o.data = store_val;
        res_o.pos  = 8'(cnt_q);
        cnt_d      = cnt_q + CW'(1);
      end else begin
        res_o.ev = EV_OVERFLOW;
      end
    end
  end

  // framing state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
      cnt_q    <= '0;
    end else if (en_i) begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== design/kfd_contact.sv =====
// kfd_contact: saturating day counter and recent contact flag
// depends on kfd_pkg
module kfd_contact (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  kfd_pkg::contact_ctl_t ctl_i,
  input  logic [15:0]           limit_i,
  output logic                  recent_o
);
  import kfd_pkg::*;

  logic [15:0] days_q, days_d;

  // clear on a good frame, count up on a day tick
  always_comb begin
    days_d = days_q;
    priority if (ctl_i.clear) begin
      days_d = '0;
    end else if (ctl_i.tick && days_q != DAYS_MAX) begin
      days_d = days_q + 16'd1;
    end
  end

  // flag reflects the count after this item
  assign recent_o = (days_d <= limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      days_q <= '0;
    end else if (en_i) begin
      days_q <= days_d;
    end
  end

endmodule

// ===== design/kiss_frame_deframer_core.sv =====
// KISS frame deframer core: decodes a KISS byte stream, one result per input
// transfer, with a day counter for recent ground contact. Each transfer is
// captured in an input register, decoded by a single level of framing logic
// and written to an output register, so one transfer is taken every cycle while
// the result stream is not stalled; the feedback of the framing state
// (in-frame, escape, byte count) sets that rate. s_axis_tuser selects a
// received byte (0) or a day tick (1). The contact day limit register sits at
// APB address 0 and should only be written while the block is idle.
//
// depends on kfd_pkg, kfd_decoder, kfd_contact
module kiss_frame_deframer_core #(
  parameter int unsigned MAX_FRAME_LEN = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_out, [15:8] byte_position,
                                      // [24:16] frame_length, [25] recent_contact
  output logic [2:0]  m_axis_tuser,   // [2:0] event_code
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kfd_pkg::*;

  logic        in_vld_q;
  logic        in_type_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  dec_res_t    out_res_q;
  logic        out_recent_q;
  logic [15:0] limit_q;

  logic         advance;
  dec_res_t     dec_res;
  contact_ctl_t ctl;
  logic         recent;
  reg_idx_e     reg_idx;

  // item moves to the output register when that slot is free or drains
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_type_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  kfd_decoder #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .req_type_i (in_type_q),
    .rx_byte_i  (in_byte_q),
    .res_o      (dec_res),
    .ctl_o      (ctl)
  );

  kfd_contact u_contact (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .ctl_i    (ctl),
    .limit_i  (limit_q),
    .recent_o (recent)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q    <= dec_res;
      out_recent_q <= recent;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.ev;
  assign m_axis_tdata  = {6'd0, out_recent_q, out_res_q.len, out_res_q.pos, out_res_q.data};

  // configuration register
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CONTACT_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_CONTACT_LIMIT) begin
      limit_q <= pwdata[15:0];
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_CONTACT_LIMIT: prdata = {16'd0, limit_q};
      default:           prdata = '0;
    endcase
  end

endmodule
